/* rtl/core/tald_pkg.sv */
// Shared types, constants and helpers for the tinted antialiased line draw block.
// No dependencies.
package tald_pkg;

  localparam int FB_WIDTH  = 256;
  localparam int FB_HEIGHT = 256;
  localparam int PIX_COUNT = FB_WIDTH * FB_HEIGHT;
  localparam int ADDR_W    = $clog2(PIX_COUNT);
  localparam int COORD_W   = 12;
  localparam int CH_W      = 8;
  localparam int RGB_W     = 3 * CH_W;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAY_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_WEIGHT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_THICKNESS = 2'd3;

  localparam logic [1:0] KIND_DRAW  = 2'd0;
  localparam logic [1:0] KIND_WR_OV = 2'd1;
  localparam logic [1:0] KIND_WR_FB = 2'd2;
  localparam logic [1:0] KIND_RD_FB = 2'd3;

  typedef enum logic [1:0] {
    OP_PLOT  = 2'd0,
    OP_WR_OV = 2'd1,
    OP_WR_FB = 2'd2,
    OP_RD_FB = 2'd3
  } mem_op_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic [7:0] end_x;
    logic [7:0] end_y;
    logic [7:0] brightness;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       clipped;
  } out_item_t;

  typedef struct packed {
    logic       draw_mode;
    logic       overlay_enable;
    logic [7:0] tint_weight;
    logic [3:0] line_thickness;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    mem_op_t           op;
    logic [ADDR_W-1:0] addr;
    logic [CH_W-1:0]   alpha;
    logic [RGB_W-1:0]  rgb;
  } pix_req_t;

  function automatic logic in_frame(logic signed [COORD_W-1:0] px,
                                    logic signed [COORD_W-1:0] py);
    logic signed [COORD_W:0] w;
    logic signed [COORD_W:0] h;
    w = (COORD_W+1)'(FB_WIDTH);
    h = (COORD_W+1)'(FB_HEIGHT);
    return (px >= 0) && (py >= 0) && ((COORD_W+1)'(px) < w) && ((COORD_W+1)'(py) < h);
  endfunction

  function automatic logic [ADDR_W-1:0] pix_addr(logic [COORD_W-1:0] px,
                                                 logic [COORD_W-1:0] py);
    return ADDR_W'(32'(py) * 32'(FB_WIDTH) + 32'(px));
  endfunction

endpackage

/* rtl/core/tinted_antialiased_line_draw_top.sv */
// Top level of the tinted antialiased line draw block: configuration, item
// sequencing and result register. Depends on tald_pkg, tald_walk, tald_mem.
//
// Usage:
//  - in channel (in_valid/in_ready/in_data): one item per transaction: draw a line,
//    write an overlay pixel, write a framebuffer pixel or read a framebuffer pixel.
//  - out channel (out_valid/out_ready/out_data): exactly one result per item, in
//    order; colour is the pixel read (zero otherwise), clipped flags dropped pixels.
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write only
//    while no item is in flight.
//  - A pixel access raises out_valid once it has left the memory pipe. A draw sets
//    up, runs the gradient divider, then walks each pixel position, clipped or not:
//    up to 2 per major-axis column when thin and line_thickness per column when
//    thick. A zero-length line skips the divider and walks a square of pixels.
//  - One item at a time; in_ready returns once the result sits in the output
//    register, even while the receiver stalls it. A stalled result holds.
//  - Reset: registers return to draw_mode 0, overlay off, tint weight 0, thickness 1;
//    memories are not cleared and must be written before they are read.
module tinted_antialiased_line_draw_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tald_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tald_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tald_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WAIT = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  tald_pkg::cfg_t      cfg_r;
  tald_pkg::in_item_t  item_r;
  tald_pkg::out_item_t out_data_r;
  logic                out_valid_r;
  logic [tald_pkg::RGB_W-1:0] res_r;
  tald_pkg::pix_req_t  walk_req, host_req, mem_req;
  logic walk_busy, walk_clip, walk_start, mem_busy, rd_valid, in_bounds, out_load;
  logic [tald_pkg::RGB_W-1:0] rd_data;
  logic signed [tald_pkg::COORD_W-1:0] hx, hy;

  always_comb begin
    hx = tald_pkg::COORD_W'($signed({1'b0, item_r.start_x}));
    hy = tald_pkg::COORD_W'($signed({1'b0, item_r.start_y}));
    in_bounds = tald_pkg::in_frame(hx, hy);
    walk_start = (state_r == S_EXEC) && (item_r.kind == tald_pkg::KIND_DRAW);
    host_req.valid = (state_r == S_EXEC) && (item_r.kind != tald_pkg::KIND_DRAW) && in_bounds;
    unique case (item_r.kind)
      tald_pkg::KIND_WR_OV: host_req.op = tald_pkg::OP_WR_OV;
      tald_pkg::KIND_WR_FB: host_req.op = tald_pkg::OP_WR_FB;
      tald_pkg::KIND_RD_FB: host_req.op = tald_pkg::OP_RD_FB;
      default:              host_req.op = tald_pkg::OP_PLOT;
    endcase
    host_req.addr  = tald_pkg::pix_addr(hx, hy);
    host_req.alpha = '0;
    host_req.rgb   = {item_r.red_in, item_r.green_in, item_r.blue_in};
    mem_req = host_req.valid ? host_req : walk_req;
    out_load = (state_r == S_FIN) && (!out_valid_r || out_ready);
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_WAIT;
      S_WAIT:  if (!walk_busy && !mem_busy) state_nxt = S_FIN;
      S_FIN:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  tald_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (walk_start),
    .item  (item_r),
    .cfg   (cfg_r),
    .req   (walk_req),
    .busy  (walk_busy),
    .clip  (walk_clip)
  );

  tald_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .cfg      (cfg_r),
    .busy     (mem_busy),
    .rd_valid (rd_valid),
    .rd_data  (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cfg_r.draw_mode      <= 1'b0;
      cfg_r.overlay_enable <= 1'b0;
      cfg_r.tint_weight    <= 8'd0;
      cfg_r.line_thickness <= 4'd1;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          tald_pkg::REG_DRAW_MODE:      cfg_r.draw_mode      <= cfg_data[0];
          tald_pkg::REG_OVERLAY_ENABLE: cfg_r.overlay_enable <= cfg_data[0];
          tald_pkg::REG_TINT_WEIGHT:    cfg_r.tint_weight    <= cfg_data;
          tald_pkg::REG_LINE_THICKNESS: cfg_r.line_thickness <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
    if (in_valid && in_ready) item_r <= in_data;
    if (state_r == S_EXEC) res_r <= '0;
    else if (rd_valid) res_r <= rd_data;
    if (out_load) begin
      out_data_r.red_out   <= res_r[23:16];
      out_data_r.green_out <= res_r[15:8];
      out_data_r.blue_out  <= res_r[7:0];
      out_data_r.clipped   <= (item_r.kind == tald_pkg::KIND_DRAW) ? walk_clip : !in_bounds;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |-> (!walk_busy && !mem_busy)) else $error("result before pipe drained");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_data_r)) else $error("pending result changed");
  a_read_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid |-> state_r == S_WAIT) else $error("read data outside wait");
`endif

endmodule

/* rtl/core/tald_div.sv */
// Restoring divider, one quotient bit per cycle, for the line gradient.
// Depends on tald_pkg.
module tald_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [7:0]  den,
  output logic        done,
  output logic [15:0] quo
);

  logic [tald_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0] num_r, num_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  den_r;
  logic        done_r, done_nxt;
  logic [8:0]  sh;
  logic        ge;

  always_comb begin
    sh      = {rem_r, num_r[15]};
    ge      = sh >= {1'b0, den_r};
    cnt_nxt = cnt_r;
    num_nxt = num_r;
    rem_nxt = rem_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = tald_pkg::DIV_CNT_W'(tald_pkg::DIV_STEPS);
      num_nxt = num;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      num_nxt = {num_r[14:0], ge};
      rem_nxt = ge ? 8'(sh - {1'b0, den_r}) : sh[7:0];
      done_nxt = (cnt_r == 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = num_r;

`ifndef SYNTHESIS
  a_done_after_count: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(cnt_r) == 1) else $error("divider done without final step");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> cnt_r == '0) else $error("divider restarted while busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && den_r != '0) |-> rem_r < den_r) else $error("remainder out of range");
`endif

endmodule

/* rtl/core/tald_walk.sv */
// Line walker: sets up the major axis, runs the gradient divider and walks one
// pixel per cycle, plotting those in frame. Depends on tald_pkg and tald_div.
module tald_walk (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tald_pkg::in_item_t  item,
  input  tald_pkg::cfg_t      cfg,
  output tald_pkg::pix_req_t  req,
  output logic                busy,
  output logic                clip
);

  typedef enum logic [4:0] {
    W_IDLE   = 5'b00001,
    W_SETUP  = 5'b00010,
    W_DIV    = 5'b00100,
    W_LINE   = 5'b01000,
    W_SQUARE = 5'b10000
  } wstate_t;

  localparam int CW = tald_pkg::COORD_W;

  wstate_t state_r, state_nxt;
  logic        steep_r;
  logic [7:0]  x0_r, x1_r, y0_r, dx_r, bri_r;
  logic signed [8:0]  dy_r;
  logic signed [16:0] grad_r;
  logic signed [17:0] yfp_r;
  logic [7:0]  x_r;
  logic signed [4:0] c_r, oy_r;
  logic        clip_r;
  logic        div_start, div_done;
  logic [15:0] div_quo;

  logic [7:0] adx, ady, a0, a1, b0, b1;
  logic       st;
  logic [2:0] lo3, hi3;
  logic signed [4:0] lo_s, hi_s;
  logic       thin, col_end, sq_end, emit, in_bounds;
  logic [7:0] frac, mb;
  logic [15:0] amul;
  logic signed [9:0] yi;
  logic signed [CW-1:0] major, minor, px, py;
  logic [7:0] alpha;
  logic [15:0] dmag;

  always_comb begin
    adx = (item.start_x > item.end_x) ? 8'(item.start_x - item.end_x)
                                      : 8'(item.end_x - item.start_x);
    ady = (item.start_y > item.end_y) ? 8'(item.start_y - item.end_y)
                                      : 8'(item.end_y - item.start_y);
    st = ady > adx;
    a0 = st ? item.start_y : item.start_x;
    b0 = st ? item.start_x : item.start_y;
    a1 = st ? item.end_y : item.end_x;
    b1 = st ? item.end_x : item.end_y;
    lo3 = (cfg.line_thickness == 4'd0) ? 3'd0 : 3'((cfg.line_thickness - 4'd1) >> 1);
    hi3 = 3'(cfg.line_thickness >> 1);
    lo_s = -$signed({2'b00, lo3});
    hi_s = $signed({2'b00, hi3});
    thin = (hi3 == 3'd0);
    frac = yfp_r[7:0];
    yi   = yfp_r[17:8];
    mb   = c_r[0] ? frac : 8'(8'd255 - frac);
    amul = bri_r * mb;
    col_end = thin ? (c_r[0] || frac == 8'd0) : (c_r == hi_s);
    sq_end  = (oy_r == hi_s) && (c_r == hi_s);
    dmag = dy_r[8] ? {8'(-dy_r), 8'd0} : {dy_r[7:0], 8'd0};
    if (state_r == W_SQUARE) begin
      major = CW'($signed({1'b0, x0_r})) + CW'(oy_r);
      minor = CW'($signed({1'b0, y0_r})) + CW'(c_r);
      alpha = bri_r;
    end else begin
      major = CW'($signed({1'b0, x_r}));
      minor = CW'(yi) + CW'(c_r);
      alpha = thin ? amul[15:8] : bri_r;
    end
    px = steep_r ? minor : major;
    py = steep_r ? major : minor;
    emit   = (state_r == W_LINE) || (state_r == W_SQUARE);
    in_bounds = tald_pkg::in_frame(px, py);
    req.valid = emit && in_bounds;
    req.op    = tald_pkg::OP_PLOT;
    req.addr  = tald_pkg::pix_addr(px, py);
    req.alpha = alpha;
    req.rgb   = '0;
    div_start = (state_r == W_SETUP) && (dx_r != 8'd0);
    state_nxt = state_r;
    unique case (state_r)
      W_IDLE:   if (start) state_nxt = W_SETUP;
      W_SETUP:  state_nxt = (dx_r == 8'd0) ? W_SQUARE : W_DIV;
      W_DIV:    if (div_done) state_nxt = W_LINE;
      W_LINE:   if (col_end && x_r == x1_r) state_nxt = W_IDLE;
      W_SQUARE: if (sq_end) state_nxt = W_IDLE;
      default:  state_nxt = W_IDLE;
    endcase
  end

  tald_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (dmag),
    .den   (dx_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
      clip_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start) clip_r <= 1'b0;
      else if (emit && !in_bounds) clip_r <= 1'b1;
    end
    if (start) begin
      steep_r <= st;
      bri_r   <= item.brightness;
      if (a0 > a1) begin
        x0_r <= a1; x1_r <= a0; y0_r <= b1;
        dx_r <= 8'(a0 - a1);
        dy_r <= $signed({1'b0, b0}) - $signed({1'b0, b1});
      end else begin
        x0_r <= a0; x1_r <= a1; y0_r <= b0;
        dx_r <= 8'(a1 - a0);
        dy_r <= $signed({1'b0, b1}) - $signed({1'b0, b0});
      end
    end
    unique case (state_r)
      W_SETUP: begin
        c_r  <= (dx_r == 8'd0 || !thin) ? lo_s : 5'sd0;
        oy_r <= lo_s;
        x_r  <= x0_r;
        yfp_r <= $signed({2'b00, y0_r, 8'd0});
      end
      W_DIV: begin
        grad_r <= dy_r[8] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
      end
      W_LINE: begin
        if (col_end) begin
          c_r   <= thin ? 5'sd0 : lo_s;
          x_r   <= 8'(x_r + 8'd1);
          yfp_r <= yfp_r + 18'(grad_r);
        end else begin
          c_r <= c_r + 5'sd1;
        end
      end
      W_SQUARE: begin
        if (c_r == hi_s) begin
          c_r  <= lo_s;
          oy_r <= oy_r + 5'sd1;
        end else begin
          c_r <= c_r + 5'sd1;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state_r != W_IDLE);
  assign clip = clip_r;

`ifndef SYNTHESIS
  a_emit_only_walking: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> (state_r == W_LINE || state_r == W_SQUARE))
    else $error("plot request outside walk");
  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == W_IDLE) else $error("walker started while busy");
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == W_LINE |-> dx_r != 8'd0) else $error("line walk with zero length");
`endif

endmodule

/* rtl/core/tald_mem.sv */
// Framebuffer and overlay memories with the three-stage read, blend, write-back pipe.
// Depends on tald_pkg.
module tald_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tald_pkg::pix_req_t            req,
  input  tald_pkg::cfg_t                cfg,
  output logic                          busy,
  output logic                          rd_valid,
  output logic [tald_pkg::RGB_W-1:0]    rd_data
);

  localparam int AW = tald_pkg::ADDR_W;
  localparam int RW = tald_pkg::RGB_W;

  logic [RW-1:0] fb_mem [0:tald_pkg::PIX_COUNT-1];
  logic [RW-1:0] ov_mem [0:tald_pkg::PIX_COUNT-1];

  logic          b_valid_r, c_valid_r;
  tald_pkg::mem_op_t b_op_r, c_op_r;
  logic [AW-1:0] b_addr_r, c_addr_r;
  logic [7:0]    b_alpha_r, c_alpha_r;
  logic [RW-1:0] b_rgb_r, c_rgb_r, fb_q_r, ov_q_r, c_cur_r, c_tint_r;
  logic [RW-1:0] tint_nxt, wdata;
  logic [15:0]   prod, beam;
  logic [8:0]    sum;
  logic [7:0]    o, bch;
  logic          tint_on;

  always_comb begin
    tint_on = cfg.overlay_enable && (cfg.tint_weight != 8'd0);
    tint_nxt = '0;
    o = '0;
    prod = '0;
    for (int i = 0; i < 3; i++) begin
      o    = ov_q_r[i*8 +: 8];
      prod = 16'(8'(8'd255 - o)) * 16'(cfg.tint_weight) + 16'd255;
      tint_nxt[i*8 +: 8] = tint_on ? 8'(8'd255 - prod[15:8]) : 8'd255;
    end
    wdata = c_rgb_r;
    beam  = '0;
    bch   = '0;
    sum   = '0;
    if (c_op_r == tald_pkg::OP_PLOT) begin
      for (int i = 0; i < 3; i++) begin
        beam = c_tint_r[i*8 +: 8] * c_alpha_r;
        bch  = beam[15:8];
        sum  = {1'b0, bch} + {1'b0, c_cur_r[i*8 +: 8]};
        if (cfg.draw_mode) wdata[i*8 +: 8] = bch;
        else wdata[i*8 +: 8] = sum[8] ? 8'd255 : sum[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    fb_q_r <= fb_mem[req.addr];
    ov_q_r <= ov_mem[req.addr];
    if (c_valid_r && (c_op_r == tald_pkg::OP_PLOT || c_op_r == tald_pkg::OP_WR_FB)) begin
      fb_mem[c_addr_r] <= wdata;
    end
    if (c_valid_r && c_op_r == tald_pkg::OP_WR_OV) begin
      ov_mem[c_addr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      b_valid_r <= req.valid;
      c_valid_r <= b_valid_r;
    end
    b_op_r    <= req.op;
    b_addr_r  <= req.addr;
    b_alpha_r <= req.alpha;
    b_rgb_r   <= req.rgb;
    c_op_r    <= b_op_r;
    c_addr_r  <= b_addr_r;
    c_alpha_r <= b_alpha_r;
    c_rgb_r   <= b_rgb_r;
    c_cur_r   <= fb_q_r;
    c_tint_r  <= tint_nxt;
  end

  assign busy     = b_valid_r || c_valid_r;
  assign rd_valid = c_valid_r && (c_op_r == tald_pkg::OP_RD_FB);
  assign rd_data  = c_cur_r;

`ifndef SYNTHESIS
  a_no_hazard_b: assert property (@(posedge clk) disable iff (!rst_n)
    (req.valid && b_valid_r) |-> req.addr != b_addr_r)
    else $error("read of pixel still in blend stage");
  a_no_hazard_c: assert property (@(posedge clk) disable iff (!rst_n)
    (req.valid && c_valid_r) |-> req.addr != c_addr_r)
    else $error("read of pixel still in write-back stage");
  a_access_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (req.valid && req.op != tald_pkg::OP_PLOT) |-> !busy)
    else $error("pixel access overlaps other traffic");
`endif

endmodule
